[sv/assert_macros.svh]
// Assertion macros shared by the synthesizer frequency word RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed: implication");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed: next-cycle implication");

`endif

[sv/fsw_pkg.sv]
// Types, constants and band lookup for the synthesizer frequency word unit
`timescale 1ns / 1ps
package fsw_pkg;

    localparam int REQ_BITS     = 32;
    localparam int XTAL_BITS    = 27;
    localparam int WORD_BITS_DEF = 24;
    localparam int FRAC_BITS    = 16;
    localparam int HZ_BITS      = 32;

    localparam logic [XTAL_BITS-1:0] CRYSTAL_RESET = 27'd32000000;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAND = 2'd1;
    localparam logic [1:0] ST_WIDE = 2'd2;

    localparam logic [4:0] LOCK_DETECT_EN = 5'h10;

    // lodiv expressed as a multiple of four
    localparam logic [2:0] DQ_4  = 3'd1;
    localparam logic [2:0] DQ_8  = 3'd2;
    localparam logic [2:0] DQ_12 = 3'd3;
    localparam logic [2:0] DQ_16 = 3'd4;
    localparam logic [2:0] DQ_20 = 3'd5;
    localparam logic [2:0] DQ_24 = 3'd6;

    localparam logic [3:0] CODE_4  = 4'h2;
    localparam logic [3:0] CODE_8  = 4'h4;
    localparam logic [3:0] CODE_12 = 4'h6;
    localparam logic [3:0] CODE_16 = 4'h8;
    localparam logic [3:0] CODE_20 = 4'hA;
    localparam logic [3:0] CODE_24 = 4'hB;

    localparam logic [31:0] RECIP_3 = 32'hAAAAAAAB;
    localparam logic [31:0] RECIP_5 = 32'hCCCCCCCD;

    typedef struct packed {
        logic       inband;
        logic [2:0] dq;
        logic [3:0] code;
    } band_t;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] dq;
        logic [3:0] code;
    } ctl_t;

    function automatic band_t pick_band(input logic [REQ_BITS-1:0] f);
        band_t b;
        b = '{inband: 1'b1, dq: DQ_4, code: CODE_4};
        if (f <= 32'd960000000 && f >= 32'd820000000) begin
            b.dq = DQ_4;  b.code = CODE_4;
        end else if (f <= 32'd480000000 && f >= 32'd410000000) begin
            b.dq = DQ_8;  b.code = CODE_8;
        end else if (f < 32'd320000000 && f >= 32'd273300000) begin
            b.dq = DQ_12; b.code = CODE_12;
        end else if (f < 32'd240000000 && f >= 32'd205000000) begin
            b.dq = DQ_16; b.code = CODE_16;
        end else if (f <= 32'd192000000 && f >= 32'd164000000) begin
            b.dq = DQ_20; b.code = CODE_20;
        end else if (f <= 32'd160000000 && f >= 32'd136700000) begin
            b.dq = DQ_24; b.code = CODE_24;
        end else begin
            b.inband = 1'b0;
        end
        return b;
    endfunction

endpackage

[sv/fsw_front.sv]
// Band select, VCO multiply and divider seeding stage
`timescale 1ns / 1ps
module fsw_front
    import fsw_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [REQ_BITS-1:0]  request_hz,
    input  logic [XTAL_BITS-1:0] crystal,
    input  logic                 down_ready,
    output logic                 valid_o,
    output ctl_t                 ctl_o,
    output logic [XTAL_BITS-1:0] rem_o,
    output logic [WORD_BITS-1:0] low_o
);

    logic                valid_reg, valid_next;
    ctl_t                ctl_reg;
    logic [REQ_BITS-1:0] vco_reg;
    band_t               band;
    logic [63:0]         dividend;
    logic [63:0]         limit;
    logic                advance;

    assign band     = pick_band(request_hz);
    assign in_ready = !valid_reg || down_ready;
    assign advance  = in_ready;
    assign valid_next = in_valid ? 1'b1 : (down_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ctl_reg.status <= band.inband ? ST_OK : ST_BAND;
            ctl_reg.dq     <= band.dq;
            ctl_reg.code   <= band.code;
            // lodiv = 4 * dq; product stays below 2^32 in every band
            vco_reg        <= REQ_BITS'(request_hz * {27'd0, band.dq, 2'b00});
        end
    end

    // quotient fits in WORD_BITS iff dividend < crystal << WORD_BITS
    assign dividend = 64'(vco_reg) << FRAC_BITS;
    assign limit    = 64'(crystal) << WORD_BITS;

    always_comb
    begin
        ctl_o = ctl_reg;
        if (ctl_reg.status == ST_OK && dividend >= limit)
        begin
            ctl_o.status = ST_WIDE;
        end
    end

    assign valid_o = valid_reg;
    assign rem_o   = XTAL_BITS'(dividend >> WORD_BITS);
    assign low_o   = WORD_BITS'(dividend);

endmodule

[sv/fsw_div_cell.sv]
// One restoring division cell: produces one quotient bit per item
`timescale 1ns / 1ps
module fsw_div_cell
    import fsw_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [XTAL_BITS-1:0] crystal,
    input  logic                 valid_i,
    output logic                 ready_o,
    input  ctl_t                 ctl_i,
    input  logic [XTAL_BITS-1:0] rem_i,
    input  logic [WORD_BITS-1:0] low_i,
    input  logic                 down_ready,
    output logic                 valid_o,
    output ctl_t                 ctl_o,
    output logic [XTAL_BITS-1:0] rem_o,
    output logic [WORD_BITS-1:0] low_o
);

    logic                 valid_reg;
    ctl_t                 ctl_reg;
    logic [XTAL_BITS-1:0] rem_reg, rem_next;
    logic [WORD_BITS-1:0] low_reg, low_next;
    logic [XTAL_BITS:0]   trial;
    logic                 ge;

    assign ready_o = !valid_reg || down_ready;

    // shift in the next dividend bit, subtract when it fits
    assign trial    = {rem_i, low_i[WORD_BITS-1]};
    assign ge       = trial >= {1'b0, crystal};
    assign rem_next = ge ? XTAL_BITS'(trial - {1'b0, crystal}) : XTAL_BITS'(trial);
    assign low_next = {low_i[WORD_BITS-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_o)
        begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_o && valid_i)
        begin
            ctl_reg <= ctl_i;
            rem_reg <= rem_next;
            low_reg <= low_next;
        end
    end

    assign valid_o = valid_reg;
    assign ctl_o   = ctl_reg;
    assign rem_o   = rem_reg;
    assign low_o   = low_reg;

endmodule

[sv/fsw_back.sv]
// Reached-frequency pipeline: word * crystal, divide by lodiv, output register
`timescale 1ns / 1ps
module fsw_back
    import fsw_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [XTAL_BITS-1:0] crystal,
    input  logic                 valid_i,
    output logic                 ready_o,
    input  ctl_t                 ctl_i,
    input  logic [WORD_BITS-1:0] word_i,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic [4:0]           synth_cfg,
    output logic [WORD_BITS-1:0] freq_word,
    output logic [HZ_BITS-1:0]   actual_hz
);

    localparam int PROD_BITS = WORD_BITS + XTAL_BITS;

    logic                 v1_reg, v2_reg, v3_reg;
    logic                 r1, r2, r3;
    ctl_t                 c1_reg, c2_reg;
    logic [WORD_BITS-1:0] w1_reg, w2_reg;
    logic [PROD_BITS-1:0] prod_reg;
    logic [HZ_BITS-1:0]   reached;
    logic [29:0]          x_next, x_reg;
    logic [31:0]          recip;
    logic [61:0]          p_reg;
    logic [29:0]          quot;
    logic [1:0]           status_reg;
    logic [4:0]           cfg_reg;
    logic [WORD_BITS-1:0] word_reg;
    logic [HZ_BITS-1:0]   hz_reg;

    assign r3      = !v3_reg || out_ready;
    assign r2      = !v2_reg || r3;
    assign r1      = !v1_reg || r2;
    assign ready_o = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= valid_i;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
        end
    end

    // stage 1: word * crystal
    always_ff @(posedge clk)
    begin
        if (r1 && valid_i)
        begin
            c1_reg   <= ctl_i;
            w1_reg   <= word_i;
            prod_reg <= PROD_BITS'(word_i) * PROD_BITS'(crystal);
        end
    end

    // stage 2: drop the fraction, strip the factor four, multiply by reciprocal
    assign reached = HZ_BITS'(64'(prod_reg) >> FRAC_BITS);
    assign x_next  = reached[31:2];

    always_comb
    begin
        case (c1_reg.dq)
            DQ_12, DQ_24: recip = RECIP_3;
            DQ_20:        recip = RECIP_5;
            default:      recip = 32'd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (r2 && v1_reg)
        begin
            c2_reg <= c1_reg;
            w2_reg <= w1_reg;
            x_reg  <= x_next;
            p_reg  <= 62'(x_next) * 62'(recip);
        end
    end

    // stage 3: pick the quotient; on error keep the status and zero config, word and frequency
    always_comb
    begin
        case (c2_reg.dq)
            DQ_4:         quot = x_reg;
            DQ_8:         quot = x_reg >> 1;
            DQ_16:        quot = x_reg >> 2;
            DQ_12:        quot = 30'(p_reg >> 33);
            DQ_20, DQ_24: quot = 30'(p_reg >> 34);
            default:      quot = 30'd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (r3 && v2_reg)
        begin
            status_reg <= c2_reg.status;
            if (c2_reg.status == ST_OK)
            begin
                cfg_reg  <= LOCK_DETECT_EN | {1'b0, c2_reg.code};
                word_reg <= w2_reg;
                hz_reg   <= {2'b00, quot};
            end
            else
            begin
                cfg_reg  <= 5'd0;
                word_reg <= '0;
                hz_reg   <= '0;
            end
        end
    end

    assign out_valid = v3_reg;
    assign status    = status_reg;
    assign synth_cfg = cfg_reg;
    assign freq_word = word_reg;
    assign actual_hz = hz_reg;

endmodule

[sv/rf_synth_frequency_word_unit.sv]
// Top level of the synthesizer frequency word unit
// Path: front stage register, the divider cells, then the back stages up to the output register.
// Throughput: one request per cycle while out_ready holds; the divider is a row of WORD_BITS cells,
// one quotient bit per cell, each holding its own item.
// Reset: all stages empty, crystal register returns to 32 MHz.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rf_synth_frequency_word_unit
    import fsw_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 crystal_we,
    input  logic [XTAL_BITS-1:0] crystal_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [REQ_BITS-1:0]  request_hz,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic [4:0]           synth_cfg,
    output logic [WORD_BITS-1:0] freq_word,
    output logic [HZ_BITS-1:0]   actual_hz
);

    logic [XTAL_BITS-1:0] crystal_reg;

    logic                 cv    [0:WORD_BITS];
    logic                 cr    [0:WORD_BITS];
    ctl_t                 cc    [0:WORD_BITS];
    logic [XTAL_BITS-1:0] crem  [0:WORD_BITS];
    logic [WORD_BITS-1:0] clow  [0:WORD_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crystal_reg <= CRYSTAL_RESET;
        end
        else if (crystal_we)
        begin
            crystal_reg <= crystal_wdata;
        end
    end

    fsw_front #(.WORD_BITS(WORD_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .request_hz (request_hz),
        .crystal    (crystal_reg),
        .down_ready (cr[0]),
        .valid_o    (cv[0]),
        .ctl_o      (cc[0]),
        .rem_o      (crem[0]),
        .low_o      (clow[0])
    );

    for (genvar i = 0; i < WORD_BITS; i++)
    begin : g_cell
        fsw_div_cell #(.WORD_BITS(WORD_BITS)) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .crystal    (crystal_reg),
            .valid_i    (cv[i]),
            .ready_o    (cr[i]),
            .ctl_i      (cc[i]),
            .rem_i      (crem[i]),
            .low_i      (clow[i]),
            .down_ready (cr[i+1]),
            .valid_o    (cv[i+1]),
            .ctl_o      (cc[i+1]),
            .rem_o      (crem[i+1]),
            .low_o      (clow[i+1])
        );
    end

    fsw_back #(.WORD_BITS(WORD_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .crystal   (crystal_reg),
        .valid_i   (cv[WORD_BITS]),
        .ready_o   (cr[WORD_BITS]),
        .ctl_i     (cc[WORD_BITS]),
        .word_i    (clow[WORD_BITS]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .synth_cfg (synth_cfg),
        .freq_word (freq_word),
        .actual_hz (actual_hz)
    );

    `ASSERT_IMPLIES(a_ok_has_lock_bit, clk, rst_n, out_valid && status == ST_OK, synth_cfg[4])
    `ASSERT_IMPLIES(a_err_zero, clk, rst_n, out_valid && status != ST_OK, synth_cfg == 5'd0 && freq_word == '0 && actual_hz == '0)
    `ASSERT_IMPLIES(a_ok_needs_crystal, clk, rst_n, out_valid && status == ST_OK, crystal_reg != '0)

endmodule
